// File: hdl/hcp_pkg.sv
package hcp_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int WIN_W       = CODE_W + BYTE_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              nonempty;
        t_cmd              head;
    } t_qstat;

endpackage

// File: hdl/hcp_ram.sv
module hcp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/hcp_front.sv
module hcp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [7:0]                  i_symbol,
    input  logic [hcp_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [hcp_pkg::LEN_W-1:0]   i_code_length,
    input  hcp_pkg::t_qstat             i_qstat,
    output hcp_pkg::t_push              o_push
);
    import hcp_pkg::*;

    localparam int AW        = $clog2(SYMBOL_COUNT);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic                    w_accept;
    logic                    w_sym_ok;
    logic [LEN_W-1:0]        w_len_sat;
    logic [QCNT_W:0]         w_fill;
    logic [CODE_W+LEN_W-1:0] w_rdata;
    logic                    r_s1_valid;
    logic                    r_s1_flush;

    assign w_fill     = {1'b0, i_qstat.count} + {{QCNT_W{1'b0}}, r_s1_valid};
    assign o_in_stall = (w_fill >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_sym_ok   = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
    assign w_len_sat  = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;

    hcp_ram #(
        .WIDTH(CODE_W + LEN_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_accept && (i_operation == OP_LOAD) && w_sym_ok),
        .i_waddr(i_symbol[AW-1:0]),
        .i_wdata({i_code_bits, w_len_sat}),
        .i_raddr(i_symbol[AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && (((i_operation == OP_ENCODE) && w_sym_ok)
                                       || (i_operation == OP_FLUSH));
            r_s1_flush <= (i_operation == OP_FLUSH);
        end
    end

    assign o_push.valid     = r_s1_valid;
    assign o_push.cmd.flush = r_s1_flush;
    assign o_push.cmd.code  = w_rdata[CODE_W+LEN_W-1:LEN_W];
    assign o_push.cmd.len   = w_rdata[LEN_W-1:0];

endmodule

// File: hdl/hcp_queue.sv
module hcp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcp_pkg::t_push  i_push,
    input  logic            i_pop,
    output hcp_pkg::t_qstat o_qstat
);
    import hcp_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    assign o_qstat.count    = r_count;
    assign o_qstat.nonempty = (r_count != '0);
    assign o_qstat.head     = r_entry[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |-> (r_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// File: hdl/hcp_back.sv
module hcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcp_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import hcp_pkg::*;

    logic [WIN_W-1:0]  r_win;
    logic [LEN_W-1:0]  r_total;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_last;
    logic              w_out_free;
    logic              w_emit;
    logic [CODE_W-1:0] w_code_top;
    logic [WIN_W-1:0]  w_code_win;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_total >= LEN_W'(BYTE_BITS)) && w_out_free;
    assign o_pop      = (r_total < LEN_W'(BYTE_BITS)) && i_qstat.nonempty
                        && (!i_qstat.head.flush || w_out_free);
    assign w_code_top = i_qstat.head.code << (LEN_W'(CODE_W) - i_qstat.head.len);
    assign w_code_win = {w_code_top, {BYTE_BITS{1'b0}}} >> r_total[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_last      <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_win[WIN_W-1 -: BYTE_BITS];
                r_last      <= (r_total < LEN_W'(2 * BYTE_BITS));
                r_win       <= r_win << BYTE_BITS;
                r_total     <= r_total - LEN_W'(BYTE_BITS);
            end else if (o_pop) begin
                if (i_qstat.head.flush) begin
                    if (r_total != '0) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_win[WIN_W-1 -: BYTE_BITS];
                        r_last      <= 1'b1;
                    end
                    r_win   <= '0;
                    r_total <= '0;
                end else if (i_qstat.head.len != '0) begin
                    r_win   <= r_win | w_code_win;
                    r_total <= r_total + i_qstat.head.len;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

endmodule

// File: hdl/huffman_code_packer_core.sv
// huffman_code_packer_core
// input channel: i_in_valid / o_in_stall with i_operation, i_symbol, i_code_bits,
//   i_code_length. load words write the code table, encode words append the
//   symbol's code to the bit stream, flush words emit the pending partial byte.
// output channel: o_out_valid / i_out_stall with o_out_byte (earliest bit in
//   bit 7) and o_last, set on the final byte that one input word causes.
// path: an encode word passes the table read register and the queue to reach
//   the packer, which gathers its bits and registers each byte for output.
// throughput: the front takes one word per cycle while the four-entry queue has
//   room; the packer pops a queued word only while fewer than eight bits are
//   pending, so it takes no new word until the bytes of the last are out.
// reset: synchronous, active low; clears the queue, the pending bits and the
//   output register. table contents are kept and must be loaded before use.
// stall: while i_out_stall holds a byte, no byte is emitted and the packer pops
//   only below 8 pending bits; o_in_stall rises once queue and front hold four.
module huffman_code_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_symbol,
    input  logic [hcp_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hcp_pkg::LEN_W-1:0]  i_code_length,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_last
);
    import hcp_pkg::*;

    t_push  w_push;
    t_qstat w_qstat;
    logic   w_pop;

    hcp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_symbol     (i_symbol),
        .i_code_bits  (i_code_bits),
        .i_code_length(i_code_length),
        .i_qstat      (w_qstat),
        .o_push       (w_push)
    );

    hcp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (w_pop),
        .o_qstat(w_qstat)
    );

    hcp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
